/* hw/rtl/mhpq_pkg.sv */
`timescale 1ns / 1ps
package mhpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_PRINT  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_INSERTED    = 4'd0,
        ST_FULL        = 4'd1,
        ST_DUP         = 4'd2,
        ST_DELETED     = 4'd3,
        ST_EMPTY_DEL   = 4'd4,
        ST_FOUND       = 4'd5,
        ST_NOT_FOUND   = 4'd6,
        ST_PRINT       = 4'd7,
        ST_PRINT_EMPTY = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DEL_ROOT,
        S_DN_RD,
        S_DN_CMP,
        S_PRINT_RD,
        S_PRINT_OUT
    } t_state;

    // Signed compare result from the shared comparator.
    typedef struct packed {
        logic a_gt_b;
        logic a_eq_b;
    } t_cmp;

endpackage

/* hw/rtl/mhpq_cmp.sv */
`timescale 1ns / 1ps
module mhpq_cmp (
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output mhpq_pkg::t_cmp     o_res
);
    assign o_res.a_gt_b = (i_a > i_b);
    assign o_res.a_eq_b = (i_a == i_b);
endmodule

/* hw/rtl/max_heap_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Binary max-heap priority queue of signed 32-bit keys.
// Commands: raise start with i_opcode and i_key_in while busy is low; the command
// is taken at that edge and busy stays high until its last result has been issued.
// Opcodes: insert, delete max, find, print. Each result appears for exactly one cycle
// with o_valid high, carrying o_status, o_key_out and o_last; the receiver must take it
// then, as results cannot be held off. Print issues one result per stored key.
// Inserts into a full heap, deletes of an empty heap and prints of an empty heap answer
// from idle without raising busy. Find scans the stored keys one at a time through the
// single store read port and one shared comparator, reading then comparing each. An
// insert first scans for a duplicate, then appends the key and moves it up level by
// level. Delete reads the root and the last entry, then walks down level by level.
// Print reads and issues each key in turn.
// One command is in flight at a time; the store port and comparator set the rate.
// Writing i_cfg_we with i_cfg_capacity while idle sets the capacity (saturated to
// HEAP_DEPTH) and empties the heap. Reset empties the heap and sets capacity to 32.
module max_heap_priority_queue_unit #(
    parameter int HEAP_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_capacity,
    input  logic               start,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_key_in,
    output logic               busy,
    output logic               o_valid,
    output logic [3:0]         o_status,
    output logic signed [31:0] o_key_out,
    output logic               o_last
);
    localparam int AW = $clog2(HEAP_DEPTH + 1);

    logic signed [31:0] r_mem [1:HEAP_DEPTH];
    logic signed [31:0] r_rd;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    mhpq_pkg::t_state r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [6:0]         r_cap;
    logic [AW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_j, n_j;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_cur, n_cur;
    logic signed [31:0] r_lft, n_lft;
    logic [1:0]         r_op, n_op;
    logic               r_sub, n_sub;

    logic               n_valid, n_last;
    logic [3:0]         n_status;
    logic signed [31:0] n_kout;

    logic signed [31:0] cmp_a, cmp_b;
    mhpq_pkg::t_cmp     cmp;
    logic [AW:0]        eff_cap;
    logic [AW:0]        l2, r2;

    mhpq_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_res(cmp));

    assign eff_cap = (r_cap > 7'(HEAP_DEPTH)) ? (AW+1)'(HEAP_DEPTH) : (AW+1)'(r_cap);
    assign l2      = {r_i, 1'b0};
    assign r2      = {r_i, 1'b1};
    assign busy    = (r_state != mhpq_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_cap   <= 7'd32;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_valid <= n_valid;
            if (i_cfg_we) begin
                r_cap <= {1'b0, i_cfg_capacity};
                r_cnt <= '0;
            end
        end
        r_i <= n_i; r_j <= n_j; r_key <= n_key; r_cur <= n_cur;
        r_lft <= n_lft; r_op <= n_op; r_sub <= n_sub;
        o_status <= n_status; o_key_out <= n_kout; o_last <= n_last;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_key = r_key;
        n_cur = r_cur; n_lft = r_lft; n_op = r_op; n_sub = r_sub;
        n_valid = 1'b0; n_last = 1'b1; n_status = mhpq_pkg::ST_INSERTED; n_kout = r_key;
        rd_addr = r_i; we = 1'b0; wr_addr = r_i; wr_data = r_key;
        cmp_a = r_rd; cmp_b = r_key;
        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (start) begin
                    n_op = i_opcode; n_key = i_key_in; n_i = AW'(1);
                    case (mhpq_pkg::t_opcode'(i_opcode))
                        mhpq_pkg::OP_INSERT: begin
                            if ({1'b0, r_cnt} >= eff_cap) begin
                                n_valid = 1'b1; n_status = mhpq_pkg::ST_FULL; n_kout = i_key_in;
                            end else begin
                                n_state = mhpq_pkg::S_SCAN_RD;
                            end
                        end
                        mhpq_pkg::OP_FIND: n_state = mhpq_pkg::S_SCAN_RD;
                        mhpq_pkg::OP_DELETE: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1; n_status = mhpq_pkg::ST_EMPTY_DEL; n_kout = '0;
                            end else begin
                                n_state = mhpq_pkg::S_DEL_RD;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_valid = 1'b1; n_status = mhpq_pkg::ST_PRINT_EMPTY;
                                n_kout = '0;
                            end else begin
                                n_state = mhpq_pkg::S_PRINT_RD;
                            end
                        end
                    endcase
                end
            end
            // Linear scan for the key; read then compare each entry in turn.
            mhpq_pkg::S_SCAN_RD: begin
                if (r_i > r_cnt) begin
                    if (r_op == mhpq_pkg::OP_FIND) begin
                        n_valid = 1'b1; n_status = mhpq_pkg::ST_NOT_FOUND;
                        n_state = mhpq_pkg::S_IDLE;
                    end else begin
                        // Append at the end, then percolate up from there.
                        we = 1'b1; wr_addr = AW'(r_cnt + 1'b1);
                        n_cnt = AW'(r_cnt + 1'b1);
                        n_i = AW'(r_cnt + 1'b1);
                        n_state = mhpq_pkg::S_UP_RD;
                    end
                end else begin
                    rd_addr = r_i;
                    n_state = mhpq_pkg::S_SCAN_CMP;
                end
            end
            mhpq_pkg::S_SCAN_CMP: begin
                if (cmp.a_eq_b) begin
                    n_valid = 1'b1;
                    n_status = (r_op == mhpq_pkg::OP_FIND) ? mhpq_pkg::ST_FOUND
                                                            : mhpq_pkg::ST_DUP;
                    n_state = mhpq_pkg::S_IDLE;
                end else begin
                    n_i = AW'(r_i + 1'b1);
                    n_state = mhpq_pkg::S_SCAN_RD;
                end
            end
            // The new key (r_key) sits at r_i; read its parent.
            mhpq_pkg::S_UP_RD: begin
                if (r_i == AW'(1)) begin
                    we = 1'b1; wr_addr = r_i; wr_data = r_key;
                    n_valid = 1'b1; n_status = mhpq_pkg::ST_INSERTED;
                    n_state = mhpq_pkg::S_IDLE;
                end else begin
                    rd_addr = r_i >> 1;
                    n_state = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                cmp_a = r_key; cmp_b = r_rd;
                if (cmp.a_gt_b) begin
                    we = 1'b1; wr_addr = r_i; wr_data = r_rd;
                    n_i = r_i >> 1;
                    n_state = mhpq_pkg::S_UP_RD;
                end else begin
                    we = 1'b1; wr_addr = r_i; wr_data = r_key;
                    n_valid = 1'b1; n_status = mhpq_pkg::ST_INSERTED;
                    n_state = mhpq_pkg::S_IDLE;
                end
                if (cmp.a_gt_b && (r_i >> 1) == AW'(1)) begin
                    // Reached the root; the next step writes the key there.
                    n_state = mhpq_pkg::S_UP_RD;
                end
            end
            // Delete: read root, then the last entry.
            mhpq_pkg::S_DEL_RD: begin
                rd_addr = AW'(1);
                n_state = mhpq_pkg::S_DEL_ROOT;
            end
            mhpq_pkg::S_DEL_ROOT: begin
                n_kout = r_rd; n_lft = r_rd;
                rd_addr = r_cnt;
                n_cnt = AW'(r_cnt - 1'b1);
                n_i = AW'(1); n_sub = 1'b0; n_j = '0;
                n_state = mhpq_pkg::S_DN_RD;
            end
            // Down walk: r_cur is the moving key, r_lft holds the deleted root.
            // Sub-step 0 reads the left child, sub-step 1 the right child.
            mhpq_pkg::S_DN_RD: begin
                n_kout = r_lft;
                if (r_sub == 1'b0 && r_i == AW'(1) && r_j == '0) begin
                    n_cur = r_rd; n_j = AW'(1);
                end
                if (l2 > {1'b0, r_cnt}) begin
                    we = 1'b1; wr_addr = r_i; wr_data = (r_i == AW'(1) && r_j == '0)
                                                         ? r_rd : r_cur;
                    n_valid = 1'b1; n_status = mhpq_pkg::ST_DELETED; n_kout = r_lft;
                    n_j = '0;
                    n_state = mhpq_pkg::S_IDLE;
                end else begin
                    rd_addr = r_sub ? AW'(r2) : AW'(l2);
                    n_state = mhpq_pkg::S_DN_CMP;
                end
            end
            mhpq_pkg::S_DN_CMP: begin
                n_kout = r_lft;
                if (r_sub == 1'b0) begin
                    if (l2 == {1'b0, r_cnt}) begin
                        cmp_a = r_rd; cmp_b = r_cur;
                        we = 1'b1; n_j = '0;
                        if (cmp.a_gt_b) begin
                            wr_addr = r_i; wr_data = r_rd;
                            n_i = AW'(l2);
                            n_state = mhpq_pkg::S_DN_RD;
                            n_j = AW'(1);
                        end else begin
                            wr_addr = r_i; wr_data = r_cur;
                            n_valid = 1'b1; n_status = mhpq_pkg::ST_DELETED;
                            n_state = mhpq_pkg::S_IDLE;
                        end
                    end else begin
                        n_key = r_rd; n_sub = 1'b1;
                        n_state = mhpq_pkg::S_DN_RD;
                    end
                end else begin
                    // r_key = left child, r_rd = right child.
                    cmp_a = r_key; cmp_b = r_rd;
                    n_sub = 1'b0;
                    we = 1'b1; wr_addr = r_i;
                    if (r_cur > r_key && r_cur > r_rd) begin
                        wr_data = r_cur;
                        n_valid = 1'b1; n_status = mhpq_pkg::ST_DELETED;
                        n_j = '0;
                        n_state = mhpq_pkg::S_IDLE;
                    end else if (cmp.a_gt_b) begin
                        wr_data = r_key; n_i = AW'(l2); n_j = AW'(1);
                        n_state = mhpq_pkg::S_DN_RD;
                    end else begin
                        wr_data = r_rd; n_i = AW'(r2); n_j = AW'(1);
                        n_state = mhpq_pkg::S_DN_RD;
                    end
                end
            end
            mhpq_pkg::S_PRINT_RD: begin
                rd_addr = r_i;
                n_state = mhpq_pkg::S_PRINT_OUT;
            end
            mhpq_pkg::S_PRINT_OUT: begin
                n_valid = 1'b1; n_status = mhpq_pkg::ST_PRINT; n_kout = r_rd;
                n_last = (r_i == r_cnt);
                n_i = AW'(r_i + 1'b1);
                n_state = (r_i == r_cnt) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_PRINT_RD;
            end
            default: n_state = mhpq_pkg::S_IDLE;
        endcase
    end
endmodule
